// ===== design/kms_pkg.sv =====
// Package for the scalar Kalman measurement update block.
// Holds default sizes, operation and status codes, controller states and
// the saturation helpers shared by the datapath modules. No dependencies.
package kms_pkg;

  localparam int MAX_STATES_DEF = 64;
  localparam int MAX_TERMS_DEF  = 8;
  localparam int VALUE_BITS_DEF = 64;

  localparam logic [2:0] OP_WR_STATE = 3'd0;
  localparam logic [2:0] OP_WR_COV   = 3'd1;
  localparam logic [2:0] OP_TERM     = 3'd2;
  localparam logic [2:0] OP_RD_STATE = 3'd3;
  localparam logic [2:0] OP_RD_COV   = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NONPOS = 2'd1;
  localparam logic [1:0] ST_BAD    = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RD_OUT,
    S_G_ADDR,
    S_G_MUL,
    S_G_WAIT,
    S_G_WR,
    S_P_ADDR,
    S_P_MUL1,
    S_P_WAIT1,
    S_P_MUL2,
    S_P_WAIT2,
    S_FIN,
    S_X_ADDR,
    S_X_MUL,
    S_X_WM,
    S_X_DIV,
    S_X_WD,
    S_C_ROW,
    S_C_ROWL,
    S_C_ADDR,
    S_C_MUL,
    S_C_WM,
    S_C_DIV,
    S_C_WD,
    S_RESULT
  } state_t;

  function automatic logic [63:0] sat_sum(logic signed [64:0] v, logic [63:0] vmax);
    logic signed [64:0] hi;
    logic signed [64:0] lo;
    hi = $signed({1'b0, vmax});
    lo = $signed(~{1'b0, vmax});
    if (v > hi) begin
      sat_sum = vmax;
    end else if (v < lo) begin
      sat_sum = ~vmax;
    end else begin
      sat_sum = v[63:0];
    end
  endfunction

  function automatic logic [63:0] sat_mag(logic neg, logic [63:0] r, logic over,
                                          logic [63:0] vmax);
    if (over || (r > vmax)) begin
      sat_mag = neg ? ~vmax : vmax;
    end else begin
      sat_mag = neg ? (~r + 64'd1) : r;
    end
  endfunction

endpackage

// ===== design/kms_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module kms_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                      wdata,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== design/kms_mul.sv =====
// Sequential Q31.32 multiplier: four 32x32 partial products, one per cycle,
// then rounding half away from zero and saturation. Depends on kms_pkg.
module kms_mul #(
  parameter int VALUE_BITS = kms_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] res
);

  localparam logic [63:0] VMAX = 64'((65'd1 << (VALUE_BITS - 1)) - 65'd1);

  logic [63:0]  ua_r, ub_r;
  logic         neg_r;
  logic [127:0] acc_r;
  logic [2:0]   cnt_r;
  logic         run_r, done_r;
  logic [63:0]  res_r;

  logic [31:0]  ah, bh;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [127:0] rnd;

  always_comb begin
    ah    = cnt_r[1] ? ua_r[63:32] : ua_r[31:0];
    bh    = cnt_r[0] ? ub_r[63:32] : ub_r[31:0];
    pp    = {32'd0, ah} * {32'd0, bh};
    pp_sh = {64'd0, pp} << (7'(cnt_r[1]) + 7'(cnt_r[0])) * 7'd32;
    rnd   = acc_r + 128'h8000_0000;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        ua_r  <= a[63] ? (~a + 64'd1) : a;
        ub_r  <= b[63] ? (~b + 64'd1) : b;
        neg_r <= a[63] ^ b[63];
        acc_r <= '0;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        if (cnt_r == 3'd4) begin
          res_r  <= kms_pkg::sat_mag(neg_r, rnd[95:32], |rnd[127:96], VMAX);
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          acc_r <= acc_r + pp_sh;
          cnt_r <= cnt_r + 3'd1;
        end
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

// ===== design/kms_div.sv =====
// Bit-serial Q31.32 divider by a positive divisor: one quotient bit per
// cycle, truncated, then saturated. Depends on kms_pkg.
module kms_div #(
  parameter int VALUE_BITS = kms_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] res
);

  localparam logic [63:0] VMAX = 64'((65'd1 << (VALUE_BITS - 1)) - 65'd1);

  logic [95:0] dv_r, q_r;
  logic [63:0] rem_r, b_r;
  logic        neg_r;
  logic [6:0]  cnt_r;
  logic        run_r, done_r;
  logic [63:0] res_r;

  logic [64:0] rem_sh, diff;
  logic        ge;

  always_comb begin
    rem_sh = {rem_r, dv_r[95]};
    diff   = rem_sh - {1'b0, b_r};
    ge     = rem_sh >= {1'b0, b_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        dv_r  <= {(a[63] ? (~a + 64'd1) : a), 32'd0};
        b_r   <= b;
        neg_r <= a[63];
        rem_r <= '0;
        q_r   <= '0;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        if (cnt_r == 7'd96) begin
          res_r  <= kms_pkg::sat_mag(neg_r, q_r[63:0], |q_r[95:64], VMAX);
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          rem_r <= ge ? diff[63:0] : rem_sh[63:0];
          q_r   <= {q_r[94:0], ge};
          dv_r  <= {dv_r[94:0], 1'b0};
          cnt_r <= cnt_r + 7'd1;
        end
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

// ===== design/kalman_scalar_measurement_update.sv =====
// Top level of the scalar Kalman measurement update block.
// Depends on kms_pkg, kms_ram, kms_mul and kms_div.
//
// Usage: an item is a transfer at a clock edge with start high and busy low.
// Ops 0 and 1 write the state vector or the packed covariance; their result
// appears on the next cycle and busy stays low. Ops 3 and 4 read an element;
// it goes through the registered memory read and then the result register.
// Measurement terms that are not last are buffered with no result. A last
// term runs the update: with n active states and m terms it forms the gain
// column, then the predictions, then the state update and the update of the
// n*(n+1)/2 covariance elements; every updated element passes through the
// shared bit-serial divider. Without an update, or with a nonpositive
// variance, only the first two phases run. Every result is shown for one
// cycle with out_strobe high; the receiver cannot stall and must take it
// then. Reset clears the controller, the term buffer and sets active_states
// to its maximum; state and covariance memories hold nothing defined until
// written.
module kalman_scalar_measurement_update #(
  parameter int MAX_STATES = kms_pkg::MAX_STATES_DEF,
  parameter int MAX_TERMS  = kms_pkg::MAX_TERMS_DEF,
  parameter int VALUE_BITS = kms_pkg::VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_op,
  input  logic [11:0]        in_element_index,
  input  logic signed [63:0] in_write_value,
  input  logic [5:0]         in_term_index,
  input  logic signed [63:0] in_term_coeff,
  input  logic               in_last_term,
  input  logic signed [63:0] in_measurement,
  input  logic [62:0]        in_noise_variance,
  input  logic               in_apply_update,
  input  logic               cfg_write_enable,
  input  logic [6:0]         cfg_write_data,
  output logic               out_strobe,
  output logic signed [63:0] out_read_value,
  output logic signed [63:0] out_predicted_measurement,
  output logic signed [63:0] out_predicted_variance,
  output logic signed [63:0] out_innovation,
  output logic [1:0]         out_status
);

  localparam int COV_DEPTH = MAX_STATES * (MAX_STATES + 1) / 2;
  localparam int SW   = $clog2(MAX_STATES);
  localparam int NW   = $clog2(MAX_STATES + 1);
  localparam int CW   = $clog2(COV_DEPTH);
  localparam int TW   = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNTW = $clog2(MAX_TERMS + 1);
  localparam logic [63:0] VMAX = 64'((65'd1 << (VALUE_BITS - 1)) - 65'd1);

  kms_pkg::state_t state_r, state_nxt;

  logic [NW-1:0]   n_r, n_nxt;
  logic [CNTW-1:0] tc_r, tc_nxt, m_r, m_nxt;
  logic            terr_r, terr_nxt;
  logic [5:0]      tidx_r [MAX_TERMS];
  logic [63:0]     tcoef_r [MAX_TERMS];
  logic            term_we;
  logic [SW-1:0]   i_r, i_nxt, jj_r, jj_nxt;
  logic [TW-1:0]   j_r, j_nxt;
  logic [CW-1:0]   k_r, k_nxt;
  logic [63:0]     acc_r, acc_nxt, rp_r, rp_nxt, zp_r, zp_nxt;
  logic [63:0]     z_r, z_nxt, r_r, r_nxt, gi_r, gi_nxt, hold_r, hold_nxt;
  logic            upd_r, upd_nxt, rdsel_r, rdsel_nxt;
  logic [1:0]      fstat_r, fstat_nxt;

  logic            ostb_r, ostb_nxt;
  logic [63:0]     ord_r, ord_nxt, opm_r, opm_nxt, opv_r, opv_nxt, oin_r, oin_nxt;
  logic [1:0]      ost_r, ost_nxt;

  logic            st_we, gn_we, cv_we;
  logic [SW-1:0]   st_addr, gn_addr;
  logic [CW-1:0]   cv_addr;
  logic [63:0]     st_wdata, gn_wdata, cv_wdata, st_rdata, gn_rdata, cv_rdata;

  logic            mul_start, mul_done, div_start, div_done;
  logic [63:0]     mul_a, mul_b, mul_res, div_res;

  logic            accept, st_ok, cv_ok, term_bad, bad_stored, last_err, ilast, jlast;
  logic [CNTW-1:0] new_count;
  logic [63:0]     wv, tcv, zv, rv, innov_c, s_c;
  logic            s_nonpos;
  logic [SW-1:0]   g_t, g_hi, g_lo;
  logic [2*SW:0]   g_prod;
  logic [CW-1:0]   g_addr;

  kms_ram #(.WIDTH(64), .DEPTH(MAX_STATES)) u_state_ram (
    .clk(clk), .we(st_we), .addr(st_addr), .wdata(st_wdata), .rdata(st_rdata)
  );
  kms_ram #(.WIDTH(64), .DEPTH(MAX_STATES)) u_gain_ram (
    .clk(clk), .we(gn_we), .addr(gn_addr), .wdata(gn_wdata), .rdata(gn_rdata)
  );
  kms_ram #(.WIDTH(64), .DEPTH(COV_DEPTH)) u_cov_ram (
    .clk(clk), .we(cv_we), .addr(cv_addr), .wdata(cv_wdata), .rdata(cv_rdata)
  );
  kms_mul #(.VALUE_BITS(VALUE_BITS)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .res(mul_res)
  );
  kms_div #(.VALUE_BITS(VALUE_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .a(mul_res), .b(s_c),
    .done(div_done), .res(div_res)
  );

  always_comb begin
    busy   = (state_r != kms_pkg::S_IDLE);
    accept = start && !busy;
    st_ok  = 32'(in_element_index) < 32'(MAX_STATES);
    cv_ok  = 32'(in_element_index) < 32'(COV_DEPTH);
    wv     = kms_pkg::sat_sum({in_write_value[63], in_write_value}, VMAX);
    tcv    = kms_pkg::sat_sum({in_term_coeff[63], in_term_coeff}, VMAX);
    zv     = kms_pkg::sat_sum({in_measurement[63], in_measurement}, VMAX);
    rv     = kms_pkg::sat_sum({2'b00, in_noise_variance}, VMAX);
    term_bad  = (32'(tc_r) >= 32'(MAX_TERMS)) || (32'(in_term_index) >= 32'(n_r));
    new_count = term_bad ? tc_r : tc_r + CNTW'(1);
    bad_stored = 1'b0;
    for (int q = 0; q < MAX_TERMS; q++) begin
      if ((q < int'(tc_r)) && (int'(tidx_r[q]) >= int'(n_r))) begin
        bad_stored = 1'b1;
      end
    end
    last_err = terr_r || term_bad || bad_stored;
    ilast    = (32'(i_r) + 32'd1) == 32'(n_r);
    jlast    = (32'(j_r) + 32'd1) == 32'(m_r);
    innov_c  = kms_pkg::sat_sum($signed({z_r[63], z_r}) - $signed({zp_r[63], zp_r}), VMAX);
    s_c      = kms_pkg::sat_sum($signed({r_r[63], r_r}) + $signed({rp_r[63], rp_r}), VMAX);
    s_nonpos = s_c[63] || (s_c == 64'd0);
    g_t      = SW'(tidx_r[j_r]);
    g_hi     = (i_r >= g_t) ? i_r : g_t;
    g_lo     = (i_r >= g_t) ? g_t : i_r;
    g_prod   = (2*SW+1)'(g_hi) * ((2*SW+1)'(g_hi) + (2*SW+1)'(1));
    g_addr   = CW'(g_prod >> 1) + CW'(g_lo);
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      kms_pkg::S_IDLE: begin
        if (accept) begin
          if (((in_op == kms_pkg::OP_RD_STATE) && st_ok) ||
              ((in_op == kms_pkg::OP_RD_COV) && cv_ok)) begin
            state_nxt = kms_pkg::S_RD_OUT;
          end else if ((in_op == kms_pkg::OP_TERM) && in_last_term && !last_err) begin
            state_nxt = kms_pkg::S_G_ADDR;
          end
        end
      end
      kms_pkg::S_RD_OUT:  state_nxt = kms_pkg::S_IDLE;
      kms_pkg::S_G_ADDR:  state_nxt = kms_pkg::S_G_MUL;
      kms_pkg::S_G_MUL:   state_nxt = kms_pkg::S_G_WAIT;
      kms_pkg::S_G_WAIT: begin
        if (mul_done) begin
          state_nxt = jlast ? kms_pkg::S_G_WR : kms_pkg::S_G_ADDR;
        end
      end
      kms_pkg::S_G_WR:    state_nxt = ilast ? kms_pkg::S_P_ADDR : kms_pkg::S_G_ADDR;
      kms_pkg::S_P_ADDR:  state_nxt = kms_pkg::S_P_MUL1;
      kms_pkg::S_P_MUL1:  state_nxt = kms_pkg::S_P_WAIT1;
      kms_pkg::S_P_WAIT1: if (mul_done) state_nxt = kms_pkg::S_P_MUL2;
      kms_pkg::S_P_MUL2:  state_nxt = kms_pkg::S_P_WAIT2;
      kms_pkg::S_P_WAIT2: begin
        if (mul_done) begin
          state_nxt = jlast ? kms_pkg::S_FIN : kms_pkg::S_P_ADDR;
        end
      end
      kms_pkg::S_FIN: begin
        state_nxt = (!s_nonpos && upd_r) ? kms_pkg::S_X_ADDR : kms_pkg::S_RESULT;
      end
      kms_pkg::S_X_ADDR:  state_nxt = kms_pkg::S_X_MUL;
      kms_pkg::S_X_MUL:   state_nxt = kms_pkg::S_X_WM;
      kms_pkg::S_X_WM:    if (mul_done) state_nxt = kms_pkg::S_X_DIV;
      kms_pkg::S_X_DIV:   state_nxt = kms_pkg::S_X_WD;
      kms_pkg::S_X_WD: begin
        if (div_done) begin
          state_nxt = ilast ? kms_pkg::S_C_ROW : kms_pkg::S_X_ADDR;
        end
      end
      kms_pkg::S_C_ROW:   state_nxt = kms_pkg::S_C_ROWL;
      kms_pkg::S_C_ROWL:  state_nxt = kms_pkg::S_C_ADDR;
      kms_pkg::S_C_ADDR:  state_nxt = kms_pkg::S_C_MUL;
      kms_pkg::S_C_MUL:   state_nxt = kms_pkg::S_C_WM;
      kms_pkg::S_C_WM:    if (mul_done) state_nxt = kms_pkg::S_C_DIV;
      kms_pkg::S_C_DIV:   state_nxt = kms_pkg::S_C_WD;
      kms_pkg::S_C_WD: begin
        if (div_done) begin
          if (jj_r != i_r) begin
            state_nxt = kms_pkg::S_C_ADDR;
          end else begin
            state_nxt = ilast ? kms_pkg::S_RESULT : kms_pkg::S_C_ROW;
          end
        end
      end
      kms_pkg::S_RESULT:  state_nxt = kms_pkg::S_IDLE;
      default:            state_nxt = kms_pkg::S_IDLE;
    endcase
  end

  // Datapath, memory control and result registers.
  always_comb begin
    n_nxt = n_r;     tc_nxt = tc_r;   terr_nxt = terr_r; m_nxt = m_r;
    i_nxt = i_r;     j_nxt = j_r;     jj_nxt = jj_r;     k_nxt = k_r;
    acc_nxt = acc_r; rp_nxt = rp_r;   zp_nxt = zp_r;
    z_nxt = z_r;     r_nxt = r_r;     upd_nxt = upd_r;   gi_nxt = gi_r;
    hold_nxt = hold_r; rdsel_nxt = rdsel_r; fstat_nxt = fstat_r;
    ostb_nxt = 1'b0; ord_nxt = ord_r; opm_nxt = opm_r;   opv_nxt = opv_r;
    oin_nxt = oin_r; ost_nxt = ost_r;
    term_we = 1'b0;
    st_we = 1'b0; gn_we = 1'b0; cv_we = 1'b0;
    st_addr = i_r; gn_addr = i_r; cv_addr = k_r;
    st_wdata = wv; gn_wdata = acc_r; cv_wdata = wv;
    mul_start = 1'b0; div_start = 1'b0;
    mul_a = 64'd0; mul_b = 64'd0;

    if (cfg_write_enable) begin
      if (cfg_write_data == 7'd0) begin
        n_nxt = NW'(1);
      end else if (32'(cfg_write_data) > 32'(MAX_STATES)) begin
        n_nxt = NW'(MAX_STATES);
      end else begin
        n_nxt = NW'(cfg_write_data);
      end
    end

    unique case (state_r)
      kms_pkg::S_IDLE: begin
        st_addr = SW'(in_element_index);
        cv_addr = CW'(in_element_index);
        if (accept) begin
          unique case (in_op)
            kms_pkg::OP_WR_STATE, kms_pkg::OP_WR_COV: begin
              st_we    = (in_op == kms_pkg::OP_WR_STATE) && st_ok;
              cv_we    = (in_op == kms_pkg::OP_WR_COV) && cv_ok;
              ostb_nxt = 1'b1;
              ord_nxt  = 64'd0; opm_nxt = 64'd0; opv_nxt = 64'd0; oin_nxt = 64'd0;
              ost_nxt  = ((in_op == kms_pkg::OP_WR_STATE) ? st_ok : cv_ok)
                         ? kms_pkg::ST_OK : kms_pkg::ST_BAD;
            end
            kms_pkg::OP_RD_STATE, kms_pkg::OP_RD_COV: begin
              rdsel_nxt = (in_op == kms_pkg::OP_RD_COV);
              if (!((in_op == kms_pkg::OP_RD_STATE) ? st_ok : cv_ok)) begin
                ostb_nxt = 1'b1;
                ord_nxt  = 64'd0; opm_nxt = 64'd0; opv_nxt = 64'd0; oin_nxt = 64'd0;
                ost_nxt  = kms_pkg::ST_BAD;
              end
            end
            kms_pkg::OP_TERM: begin
              term_we = !term_bad;
              if (!in_last_term) begin
                tc_nxt   = new_count;
                terr_nxt = terr_r || term_bad;
              end else begin
                tc_nxt   = '0;
                terr_nxt = 1'b0;
                if (last_err) begin
                  ostb_nxt = 1'b1;
                  ord_nxt  = 64'd0; opm_nxt = 64'd0; opv_nxt = 64'd0; oin_nxt = 64'd0;
                  ost_nxt  = kms_pkg::ST_BAD;
                end else begin
                  m_nxt   = new_count;
                  i_nxt   = '0;
                  j_nxt   = '0;
                  acc_nxt = 64'd0;
                  rp_nxt  = 64'd0;
                  zp_nxt  = 64'd0;
                  z_nxt   = zv;
                  r_nxt   = rv;
                  upd_nxt = in_apply_update;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      kms_pkg::S_RD_OUT: begin
        ostb_nxt = 1'b1;
        ord_nxt  = rdsel_r ? cv_rdata : st_rdata;
        opm_nxt  = 64'd0; opv_nxt = 64'd0; oin_nxt = 64'd0;
        ost_nxt  = kms_pkg::ST_OK;
      end
      kms_pkg::S_G_ADDR: cv_addr = g_addr;
      kms_pkg::S_G_MUL: begin
        mul_start = 1'b1;
        mul_a     = cv_rdata;
        mul_b     = tcoef_r[j_r];
      end
      kms_pkg::S_G_WAIT: begin
        if (mul_done) begin
          acc_nxt = kms_pkg::sat_sum($signed({acc_r[63], acc_r}) +
                                     $signed({mul_res[63], mul_res}), VMAX);
          if (!jlast) j_nxt = j_r + TW'(1);
        end
      end
      kms_pkg::S_G_WR: begin
        gn_we   = 1'b1;
        acc_nxt = 64'd0;
        j_nxt   = '0;
        i_nxt   = ilast ? '0 : i_r + SW'(1);
      end
      kms_pkg::S_P_ADDR: begin
        gn_addr = SW'(tidx_r[j_r]);
        st_addr = SW'(tidx_r[j_r]);
      end
      kms_pkg::S_P_MUL1: begin
        hold_nxt  = st_rdata;
        mul_start = 1'b1;
        mul_a     = tcoef_r[j_r];
        mul_b     = gn_rdata;
      end
      kms_pkg::S_P_WAIT1: begin
        if (mul_done) begin
          rp_nxt = kms_pkg::sat_sum($signed({rp_r[63], rp_r}) +
                                    $signed({mul_res[63], mul_res}), VMAX);
        end
      end
      kms_pkg::S_P_MUL2: begin
        mul_start = 1'b1;
        mul_a     = tcoef_r[j_r];
        mul_b     = hold_r;
      end
      kms_pkg::S_P_WAIT2: begin
        if (mul_done) begin
          zp_nxt = kms_pkg::sat_sum($signed({zp_r[63], zp_r}) +
                                    $signed({mul_res[63], mul_res}), VMAX);
          if (!jlast) j_nxt = j_r + TW'(1);
        end
      end
      kms_pkg::S_FIN: begin
        i_nxt     = '0;
        k_nxt     = '0;
        fstat_nxt = s_nonpos ? kms_pkg::ST_NONPOS : kms_pkg::ST_OK;
      end
      kms_pkg::S_X_ADDR: begin
      end
      kms_pkg::S_X_MUL: begin
        hold_nxt  = st_rdata;
        mul_start = 1'b1;
        mul_a     = gn_rdata;
        mul_b     = innov_c;
      end
      kms_pkg::S_X_WM: begin
      end
      kms_pkg::S_X_DIV: div_start = 1'b1;
      kms_pkg::S_X_WD: begin
        st_wdata = kms_pkg::sat_sum($signed({hold_r[63], hold_r}) +
                                    $signed({div_res[63], div_res}), VMAX);
        if (div_done) begin
          st_we = 1'b1;
          i_nxt = ilast ? '0 : i_r + SW'(1);
        end
      end
      kms_pkg::S_C_ROW: begin
      end
      kms_pkg::S_C_ROWL: begin
        gi_nxt = gn_rdata;
        jj_nxt = '0;
      end
      kms_pkg::S_C_ADDR: gn_addr = jj_r;
      kms_pkg::S_C_MUL: begin
        hold_nxt  = cv_rdata;
        mul_start = 1'b1;
        mul_a     = gi_r;
        mul_b     = gn_rdata;
      end
      kms_pkg::S_C_WM: begin
      end
      kms_pkg::S_C_DIV: div_start = 1'b1;
      kms_pkg::S_C_WD: begin
        cv_wdata = kms_pkg::sat_sum($signed({hold_r[63], hold_r}) -
                                    $signed({div_res[63], div_res}), VMAX);
        if (div_done) begin
          cv_we = 1'b1;
          k_nxt = k_r + CW'(1);
          if (jj_r != i_r) begin
            jj_nxt = jj_r + SW'(1);
          end else begin
            i_nxt = i_r + SW'(1);
          end
        end
      end
      kms_pkg::S_RESULT: begin
        ostb_nxt = 1'b1;
        ord_nxt  = 64'd0;
        opm_nxt  = zp_r;
        opv_nxt  = rp_r;
        oin_nxt  = innov_c;
        ost_nxt  = fstat_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kms_pkg::S_IDLE;
      n_r     <= NW'(MAX_STATES);
      tc_r    <= '0;
      terr_r  <= 1'b0;
      m_r     <= '0;
      i_r     <= '0;
      j_r     <= '0;
      jj_r    <= '0;
      k_r     <= '0;
      ostb_r  <= 1'b0;
      rdsel_r <= 1'b0;
      upd_r   <= 1'b0;
      fstat_r <= kms_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
      tc_r    <= tc_nxt;
      terr_r  <= terr_nxt;
      m_r     <= m_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      jj_r    <= jj_nxt;
      k_r     <= k_nxt;
      ostb_r  <= ostb_nxt;
      rdsel_r <= rdsel_nxt;
      upd_r   <= upd_nxt;
      fstat_r <= fstat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    rp_r   <= rp_nxt;
    zp_r   <= zp_nxt;
    z_r    <= z_nxt;
    r_r    <= r_nxt;
    gi_r   <= gi_nxt;
    hold_r <= hold_nxt;
    ord_r  <= ord_nxt;
    opm_r  <= opm_nxt;
    opv_r  <= opv_nxt;
    oin_r  <= oin_nxt;
    ost_r  <= ost_nxt;
    if (term_we) begin
      tidx_r[TW'(tc_r)]  <= in_term_index;
      tcoef_r[TW'(tc_r)] <= tcv;
    end
  end

  assign out_strobe                = ostb_r;
  assign out_read_value            = ord_r;
  assign out_predicted_measurement = opm_r;
  assign out_predicted_variance    = opv_r;
  assign out_innovation            = oin_r;
  assign out_status                = ost_r;

endmodule
